/* src/vrl_pkg.sv */
// Package for the point Verlet integrator: payload and register types,
// decay constants, the shared Q0.16 rounding multiply and the 32-bit clamp.
// No dependencies; every other file but vrl_stream_if imports it.
package vrl_pkg;

  // Register stages from the input register to the result register.
  localparam int unsigned NumStages = 9;
  // Stages held by the motion block; the settle block holds the rest.
  localparam int unsigned MotionStages = 3;

  localparam logic [15:0] LoadDecayQ16 = 16'd55050;  // 0.84
  localparam logic [15:0] ExpoDecayQ16 = 16'd60293;  // 0.92

  typedef enum logic [2:0] {
    REG_DAMPING      = 3'd0,
    REG_GRAVITY_STEP = 3'd1,
    REG_SKIN_GAIN    = 3'd2,
    REG_MUSCLE_GAIN  = 3'd3,
    REG_FRICTION     = 3'd4,
    REG_FLOOR_LEVEL  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic signed [31:0] home_x;
    logic signed [31:0] home_y;
    logic               is_muscle;
    logic               pinned;
    logic [31:0]        load_in;
    logic [15:0]        exposure_in;
  } item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_prev_x;
    logic signed [31:0] new_prev_y;
    logic [31:0]        load_out;
    logic [15:0]        exposure_out;
    logic               floor_hit;
  } result_t;

  typedef struct packed {
    logic [15:0]        damping;
    logic signed [31:0] gravity_step;
    logic [15:0]        skin_shape_gain;
    logic [15:0]        muscle_shape_gain;
    logic [15:0]        floor_friction;
    logic signed [31:0] floor_level;
  } cfg_t;

  // Point after damped motion and gravity, before the home pull.
  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    logic               is_muscle;
    logic               pinned;
    logic [31:0]        load;
    logic [15:0]        expo;
  } mot_t;

  // round(d * f / 2^16), halves toward plus infinity
  function automatic logic signed [33:0] mul_q16(input logic signed [32:0] d,
                                                 input logic [15:0] f);
    logic signed [49:0] p;
    p = 50'(d) * 50'($signed({1'b0, f}));
    p = p + 50'sd32768;
    return p[49:16];
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* src/vrl_stream_if.sv */
// Valid/ready stream channel carrying one item per handshake.
// Payload type is set by the instantiating level; no other dependencies.
interface vrl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/vrl_pipe.sv */
// Stage valid bits and stage enables of the integrator pipeline.
// Depends on vrl_pkg.
module vrl_pipe (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            out_ready_i,
  output logic [vrl_pkg::NumStages-1:0]   en_o,
  output logic                            out_valid_o
);
  import vrl_pkg::*;

  logic [NumStages-1:0] vld_q, vld_d;

  // a stage advances when empty or when the one after it advances
  always_comb begin
    en_o[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en_o[k] = !vld_q[k] || en_o[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en_o[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en_o[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign out_valid_o = vld_q[NumStages-1];
endmodule

/* src/vrl_motion.sv */
// Front stages: velocity, damping, gravity with saturation, load and
// exposure decay. Depends on vrl_pkg.
module vrl_motion (
  input  logic                                clk_i,
  input  logic [vrl_pkg::MotionStages-1:0]    en_i,
  input  vrl_pkg::item_t                      item_i,
  input  vrl_pkg::cfg_t                       cfg_i,
  output vrl_pkg::mot_t                       mot_o
);
  import vrl_pkg::*;

  // stage 0: differences and decay products
  item_t              it0_q, it1_q;
  logic signed [32:0] dx0_q, dy0_q;
  logic [47:0]        loadp0_q;
  logic [31:0]        expop0_q;
  // stage 1: damped velocity, rounded decays
  logic signed [33:0] vx1_q, vy1_q;
  logic [31:0]        load1_q;
  logic [15:0]        expo1_q;
  // stage 2: moved point
  mot_t               mot2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      it0_q    <= item_i;
      dx0_q    <= 33'(item_i.pos_x) - 33'(item_i.prev_x);
      dy0_q    <= 33'(item_i.pos_y) - 33'(item_i.prev_y);
      loadp0_q <= 48'(item_i.load_in) * 48'(LoadDecayQ16);
      expop0_q <= 32'(item_i.exposure_in) * 32'(ExpoDecayQ16);
    end
    if (en_i[1]) begin
      it1_q   <= it0_q;
      vx1_q   <= mul_q16(dx0_q, cfg_i.damping);
      vy1_q   <= mul_q16(dy0_q, cfg_i.damping);
      load1_q <= 32'((loadp0_q + 48'd32768) >> 16);
      expo1_q <= 16'((expop0_q + 32'd32768) >> 16);
    end
    if (en_i[2]) begin
      mot2_q.nx        <= sat32(35'(it1_q.pos_x) + 35'(vx1_q));
      mot2_q.ny        <= sat32(35'(it1_q.pos_y) + 35'(vy1_q) + 35'(cfg_i.gravity_step));
      mot2_q.px        <= it1_q.pos_x;
      mot2_q.py        <= it1_q.pos_y;
      mot2_q.hx        <= it1_q.home_x;
      mot2_q.hy        <= it1_q.home_y;
      mot2_q.is_muscle <= it1_q.is_muscle;
      mot2_q.pinned    <= it1_q.pinned;
      mot2_q.load      <= load1_q;
      mot2_q.expo      <= expo1_q;
    end
  end

  assign mot_o = mot2_q;
endmodule

/* src/vrl_settle.sv */
// Back stages: pull toward home, floor clamp with friction, pinned override
// and the result register. Depends on vrl_pkg.
module vrl_settle (
  input  logic                                                clk_i,
  input  logic [vrl_pkg::NumStages-vrl_pkg::MotionStages-1:0] en_i,
  input  vrl_pkg::mot_t                                       mot_i,
  input  vrl_pkg::cfg_t                                       cfg_i,
  output vrl_pkg::result_t                                    res_o
);
  import vrl_pkg::*;

  mot_t               m3_q, m4_q, m5_q, m6_q, m7_q;
  logic signed [32:0] ex3_q, ey3_q;
  logic signed [33:0] pullx4_q, pully4_q;
  logic signed [31:0] x5_q, y5_q, x6_q, y6_q, x7_q, y7_q;
  logic               hit5_q, hit6_q, hit7_q;
  logic signed [32:0] fx6_q;
  logic signed [33:0] fr7_q;
  result_t            res_q;
  logic [15:0]        gain;
  logic signed [31:0] x5_d, y5_d;

  assign gain = m3_q.is_muscle ? cfg_i.muscle_shape_gain : cfg_i.skin_shape_gain;
  assign x5_d = m4_q.nx + pullx4_q[31:0];
  assign y5_d = m4_q.ny + pully4_q[31:0];

  always_ff @(posedge clk_i) begin
    // distance to home
    if (en_i[0]) begin
      m3_q  <= mot_i;
      ex3_q <= 33'(mot_i.hx) - 33'(mot_i.nx);
      ey3_q <= 33'(mot_i.hy) - 33'(mot_i.ny);
    end
    // home pull
    if (en_i[1]) begin
      m4_q     <= m3_q;
      pullx4_q <= mul_q16(ex3_q, gain);
      pully4_q <= mul_q16(ey3_q, gain);
    end
    // pulled point and floor test
    if (en_i[2]) begin
      m5_q   <= m4_q;
      x5_q   <= x5_d;
      y5_q   <= y5_d;
      hit5_q <= !m4_q.pinned && (y5_d > cfg_i.floor_level);
    end
    // clamp to floor, horizontal velocity for friction
    if (en_i[3]) begin
      m6_q   <= m5_q;
      x6_q   <= x5_q;
      y6_q   <= hit5_q ? cfg_i.floor_level : y5_q;
      hit6_q <= hit5_q;
      fx6_q  <= 33'(m5_q.px) - 33'(x5_q);
    end
    if (en_i[4]) begin
      m7_q   <= m6_q;
      x7_q   <= x6_q;
      y7_q   <= y6_q;
      hit7_q <= hit6_q;
      fr7_q  <= mul_q16(fx6_q, cfg_i.floor_friction);
    end
    // result register; a pinned point sits at home
    if (en_i[5]) begin
      res_q.load_out     <= m7_q.load;
      res_q.exposure_out <= m7_q.expo;
      res_q.floor_hit    <= hit7_q;
      if (m7_q.pinned) begin
        res_q.new_pos_x  <= m7_q.hx;
        res_q.new_pos_y  <= m7_q.hy;
        res_q.new_prev_x <= m7_q.hx;
        res_q.new_prev_y <= m7_q.hy;
      end else begin
        res_q.new_pos_x  <= x7_q;
        res_q.new_pos_y  <= y7_q;
        res_q.new_prev_x <= hit7_q ? (x7_q + fr7_q[31:0]) : m7_q.px;
        res_q.new_prev_y <= m7_q.py;
      end
    end
  end

  assign res_o = res_q;
endmodule

/* src/point_verlet_integrator_top.sv */
// Top level of the point Verlet integrator: configuration registers and
// the nine-stage pipeline. Depends on vrl_pkg, vrl_stream_if, vrl_pipe,
// vrl_motion and vrl_settle.
//
//   channel   direction  payload   handshake
//   in_i      sink       item_t    valid/ready, taken when both high
//   out_o     source     result_t  valid/ready, taken when both high
//   cfg_*     input      index     write when cfg_we_i high, no wait
//
// One point enters per cycle while in_i.ready is high; each result passes through
// every register stage, from the input register to the result register.
// Reset clears the stage valid bits and loads the register reset values.
// An output stall holds each full stage with only full stages after it; empty
// stages still fill, so in_i.ready stays high until the pipeline is full.
module point_verlet_integrator_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  vrl_stream_if.sink       in_i,
  vrl_stream_if.source     out_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_wdata_i
);
  import vrl_pkg::*;

  cfg_t                 cfg_q;
  logic [NumStages-1:0] en;
  logic                 out_valid;
  mot_t                 mot;
  result_t              res;

  // configuration registers; writes to unused indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.damping           <= 16'hFFFF;
      cfg_q.gravity_step      <= '0;
      cfg_q.skin_shape_gain   <= '0;
      cfg_q.muscle_shape_gain <= '0;
      cfg_q.floor_friction    <= '0;
      cfg_q.floor_level       <= 32'sh7FFF_FFFF;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_DAMPING:      cfg_q.damping           <= cfg_wdata_i[15:0];
        REG_GRAVITY_STEP: cfg_q.gravity_step      <= cfg_wdata_i;
        REG_SKIN_GAIN:    cfg_q.skin_shape_gain   <= cfg_wdata_i[15:0];
        REG_MUSCLE_GAIN:  cfg_q.muscle_shape_gain <= cfg_wdata_i[15:0];
        REG_FRICTION:     cfg_q.floor_friction    <= cfg_wdata_i[15:0];
        REG_FLOOR_LEVEL:  cfg_q.floor_level       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage control: valid bits travel alongside the data
  vrl_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .en_o        (en),
    .out_valid_o (out_valid)
  );

  // stages 0..2: damped motion, gravity, decays
  vrl_motion u_motion (
    .clk_i  (clk_i),
    .en_i   (en[MotionStages-1:0]),
    .item_i (in_i.data),
    .cfg_i  (cfg_q),
    .mot_o  (mot)
  );

  // stages 3..8: home pull, floor, result register
  vrl_settle u_settle (
    .clk_i (clk_i),
    .en_i  (en[NumStages-1:MotionStages]),
    .mot_i (mot),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  assign in_i.ready  = en[0];
  assign out_o.valid = out_valid;
  assign out_o.data  = res;
endmodule

/* src/vrl_checker.sv */
// Port-level checks on the point Verlet integrator, bound to the top level.
// Depends on vrl_pkg and point_verlet_integrator_top.
module vrl_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input vrl_pkg::result_t out_data_i
);
  import vrl_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // with no result waiting, every stage can advance
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  // decayed load cannot exceed 0.84 of full scale
  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.load_out <= 32'd3607756799)
    else $error("load not decayed");

  // decayed exposure cannot exceed 0.92 of full scale
  a_expo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.exposure_out <= 16'd60292)
    else $error("exposure not decayed");
endmodule

bind point_verlet_integrator_top vrl_checker u_vrl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

/* sim/point_verlet_integrator_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for point_verlet_integrator_top: directed table, then random phases.
// Depends on vrl_pkg, vrl_stream_if and the integrator RTL; predicts in-line each point with no typed result.

module point_verlet_integrator_top_tb;
  import vrl_pkg::*;

  localparam int unsigned HalfPeriodNs   = 4;
  localparam int unsigned ResetCycles    = 7;
  localparam int unsigned NumPhases      = 6;
  localparam int unsigned PointsPerPhase = 173;
  localparam int unsigned HoldCycles     = 80;
  localparam int unsigned MaxReports     = 40;
  localparam int unsigned TimeoutNs      = 2_000_000;

  // Decay factors applied to every point, Q0.16
  localparam logic [15:0] LoadKeepQ16     = 16'd55050;
  localparam logic [15:0] ExposureKeepQ16 = 16'd60293;

  // Indexes past the register list; writes there must change nothing
  localparam logic [2:0] RegSpareA = 3'd6;
  localparam logic [2:0] RegSpareB = 3'd7;

  typedef enum logic { ROW_POINT, ROW_WRITE } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [31:0] wdata;
    item_t       pt;
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  vrl_stream_if #(.T(item_t))   in_if ();
  vrl_stream_if #(.T(result_t)) out_if ();

  point_verlet_integrator_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #(HalfPeriodNs) clk = 1'b1;
    #(HalfPeriodNs) clk = 1'b0;
  end

  cfg_t        shadow_cfg;        // register contents as the block should hold them
  result_t     stepped_due[$];    // stepped points awaiting their result, oldest first
  stim_row_t   directed[$];
  int unsigned burst_left;
  int unsigned mismatches;
  int unsigned results_seen;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Q0.16 product rounded to nearest, halves upwards; >>> on a signed value floors
  function automatic longint round_q16(longint d, logic [15:0] f);
    longint prod;
    prod = d * longint'({48'd0, f}) + 64'sd32768;
    return prod >>> 16;
  endfunction

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // One damped Verlet step of a point under the given register settings
  function automatic result_t step_point(item_t pt, cfg_t c);
    longint      px, py, qx, qy, hx, hy, vx, vy, nx, ny, npx, floor_y;
    logic [15:0] gain;
    logic [48:0] load_prod;
    logic [32:0] expo_prod;
    result_t     r;
    load_prod = 49'(pt.load_in) * 49'(LoadKeepQ16) + 49'd32768;
    expo_prod = 33'(pt.exposure_in) * 33'(ExposureKeepQ16) + 33'd32768;
    r.load_out     = load_prod[47:16];
    r.exposure_out = expo_prod[31:16];
    if (pt.pinned) begin
      // snap home, no velocity, no floor test
      r.new_pos_x  = pt.home_x;
      r.new_pos_y  = pt.home_y;
      r.new_prev_x = pt.home_x;
      r.new_prev_y = pt.home_y;
      r.floor_hit  = 1'b0;
    end else begin
      px = $signed(pt.pos_x);
      py = $signed(pt.pos_y);
      qx = $signed(pt.prev_x);
      qy = $signed(pt.prev_y);
      hx = $signed(pt.home_x);
      hy = $signed(pt.home_y);
      floor_y = longint'($signed(c.floor_level));
      gain = pt.is_muscle ? c.muscle_shape_gain : c.skin_shape_gain;
      vx = round_q16(px - qx, c.damping);
      vy = round_q16(py - qy, c.damping);
      nx = clamp_s32(px + vx);
      ny = clamp_s32(py + vy + longint'($signed(c.gravity_step)));
      nx = nx + round_q16(hx - nx, gain);
      ny = ny + round_q16(hy - ny, gain);
      npx = px;
      r.floor_hit = 1'b0;
      if (ny > floor_y) begin
        ny  = floor_y;
        npx = nx + round_q16(px - nx, c.floor_friction);
        r.floor_hit = 1'b1;
      end
      r.new_pos_x  = 32'(nx);
      r.new_pos_y  = 32'(ny);
      r.new_prev_x = 32'(npx);
      r.new_prev_y = pt.pos_y;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("MISMATCH at result %0d: %s got %h expected %h", results_seen, what, got, want);
    end
  endtask

  task automatic compare_point(result_t got, result_t want);
    if (got.new_pos_x !== want.new_pos_x)
      report_mismatch("new_pos_x", got.new_pos_x, want.new_pos_x);
    if (got.new_pos_y !== want.new_pos_y)
      report_mismatch("new_pos_y", got.new_pos_y, want.new_pos_y);
    if (got.new_prev_x !== want.new_prev_x)
      report_mismatch("new_prev_x", got.new_prev_x, want.new_prev_x);
    if (got.new_prev_y !== want.new_prev_y)
      report_mismatch("new_prev_y", got.new_prev_y, want.new_prev_y);
    if (got.load_out !== want.load_out)
      report_mismatch("load_out", got.load_out, want.load_out);
    if (got.exposure_out !== want.exposure_out)
      report_mismatch("exposure_out", 32'(got.exposure_out), 32'(want.exposure_out));
    if (got.floor_hit !== want.floor_hit)
      report_mismatch("floor_hit", 32'(got.floor_hit), 32'(want.floor_hit));
  endtask

  // Sample the result channel at the rising edge, before the block updates
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (stepped_due.size() == 0) begin
        report_mismatch("result with nothing due", out_if.data.new_pos_x, '0);
      end else begin
        want = stepped_due.pop_front();
        compare_point(out_if.data, want);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one item; open a fresh burst after a random gap when the last one ran out
  task automatic send_point(item_t pt, bit typed, result_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.data  <= pt;
    do begin
      @(posedge clk);
    end while (!in_if.ready);
    stepped_due.insert(stepped_due.size(), typed ? want : step_point(pt, shadow_cfg));
  endtask

  // Stop offering and hold until every due result has come back
  task automatic wait_settled();
    @(negedge clk);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (stepped_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_DAMPING:      shadow_cfg.damping           = val[15:0];
      REG_GRAVITY_STEP: shadow_cfg.gravity_step      = val;
      REG_SKIN_GAIN:    shadow_cfg.skin_shape_gain   = val[15:0];
      REG_MUSCLE_GAIN:  shadow_cfg.muscle_shape_gain = val[15:0];
      REG_FRICTION:     shadow_cfg.floor_friction    = val[15:0];
      REG_FLOOR_LEVEL:  shadow_cfg.floor_level       = val;
      default: ;
    endcase
  endtask

  // Junk rides in the upper half of the 16-bit registers; the block must drop it
  task automatic apply_cfg(cfg_t c, bit with_spare);
    write_reg(REG_DAMPING,      {16'($urandom), c.damping});
    write_reg(REG_GRAVITY_STEP, c.gravity_step);
    write_reg(REG_SKIN_GAIN,    {16'($urandom), c.skin_shape_gain});
    write_reg(REG_MUSCLE_GAIN,  {16'($urandom), c.muscle_shape_gain});
    write_reg(REG_FRICTION,     {16'($urandom), c.floor_friction});
    write_reg(REG_FLOOR_LEVEL,  c.floor_level);
    if (with_spare) begin
      write_reg(RegSpareA, $urandom);
      write_reg(RegSpareB, $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic item_t mk_point(logic [31:0] px, logic [31:0] py, logic [31:0] qx,
                                     logic [31:0] qy, logic [31:0] hx, logic [31:0] hy,
                                     logic mus, logic pin, logic [31:0] load,
                                     logic [15:0] expo);
    item_t pt;
    pt.pos_x       = px;
    pt.pos_y       = py;
    pt.prev_x      = qx;
    pt.prev_y      = qy;
    pt.home_x      = hx;
    pt.home_y      = hy;
    pt.is_muscle   = mus;
    pt.pinned      = pin;
    pt.load_in     = load;
    pt.exposure_in = expo;
    return pt;
  endfunction

  function automatic result_t mk_result(logic [31:0] x, logic [31:0] y, logic [31:0] qx,
                                        logic [31:0] qy, logic [31:0] load,
                                        logic [15:0] expo, logic hit);
    result_t r;
    r.new_pos_x    = x;
    r.new_pos_y    = y;
    r.new_prev_x   = qx;
    r.new_prev_y   = qy;
    r.load_out     = load;
    r.exposure_out = expo;
    r.floor_hit    = hit;
    return r;
  endfunction

  function automatic stim_row_t point_row(item_t pt, bit typed, result_t want);
    stim_row_t row;
    row.kind  = ROW_POINT;
    row.idx   = '0;
    row.wdata = '0;
    row.pt    = pt;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  function automatic stim_row_t write_row(logic [2:0] idx, logic [31:0] val);
    stim_row_t row;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.wdata = val;
    row.pt    = '0;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  // Append one row to the end of the directed table
  task automatic queue_row(stim_row_t row);
    directed.insert(directed.size(), row);
  endtask

  task automatic fill_directed();
    // Reset settings: full damping, no gravity, no pull, floor out of reach
    queue_row(point_row(mk_point(0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0),
                        1'b1, mk_result(0, 0, 0, 0, 0, 0, 1'b0)));
    // Pinned point at the corners of the range, largest load and exposure
    queue_row(point_row(
      mk_point(-1, 12345, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               1'b0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF),
      1'b1, mk_result(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'hD709_FFFF, 16'hEB84, 1'b0)));
    // Motion overflow saturating up and down; then unit load and exposure, and a pinned point
    queue_row(point_row(
      mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0,
               1'b0, 1'b0, 0, 0),
      1'b1, mk_result(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      0, 0, 1'b0)));
    queue_row(point_row(
      mk_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0,
               1'b0, 1'b0, 0, 0),
      1'b1, mk_result(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      0, 0, 1'b0)));
    queue_row(point_row(mk_point(0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 1, 1),
                        1'b1, mk_result(0, 0, 0, 0, 1, 1, 1'b0)));
    queue_row(point_row(
      mk_point(32'h8000_0000, 32'h7FFF_FFFF, 0, -1, -77, 99, 1'b1, 1'b1, 32'h8000_0000,
               16'h8000),
      1'b0, '0));
    // No damping: the point stays where it is
    queue_row(write_row(REG_DAMPING, 0));
    queue_row(point_row(mk_point(1000, -2000, 5, 7, 300, 400, 1'b0, 1'b0, 0, 0),
                        1'b1, mk_result(1000, -2000, 1000, -2000, 0, 0, 1'b0)));
    // Half damping on a unit velocity: halves round upwards
    queue_row(write_row(REG_DAMPING, 32768));
    queue_row(point_row(mk_point(1, -1, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0),
                        1'b1, mk_result(2, -1, 1, -1, 0, 0, 1'b0)));
    // Gravity, pull for both layers, friction and a floor at zero
    queue_row(write_row(REG_DAMPING, 52000));
    queue_row(write_row(REG_GRAVITY_STEP, 256));
    queue_row(write_row(REG_SKIN_GAIN, 32768));
    queue_row(write_row(REG_MUSCLE_GAIN, 65535));
    queue_row(write_row(REG_FRICTION, 32768));
    queue_row(write_row(REG_FLOOR_LEVEL, 0));
    queue_row(point_row(
      mk_point(2000, -100, 1000, -600, 0, 5000, 1'b0, 1'b0, 32'h0001_2345, 16'h1234),
      1'b0, '0));
    queue_row(point_row(
      mk_point(-3000, 800, -1000, 200, -9000, 3000, 1'b1, 1'b0, 32'hABCD_0000, 16'h7FFF),
      1'b0, '0));
    queue_row(point_row(mk_point(10, 20, 30, 40, 50, 5000, 1'b0, 1'b1, 7, 3),
                        1'b0, '0));
    queue_row(point_row(
      mk_point(500, -10000, 400, -10100, 600, -9000, 1'b0, 1'b0, 0, 0), 1'b0, '0));
    // Writes past the register list are dropped; then gravity and floor at both extremes
    queue_row(write_row(RegSpareA, 32'hFFFF_FFFF));
    queue_row(write_row(RegSpareB, 32'h5A5A_A5A5));
    queue_row(point_row(
      mk_point(2000, -100, 1000, -600, 0, 5000, 1'b0, 1'b0, 32'h0001_2345, 16'h1234),
      1'b0, '0));
    queue_row(write_row(REG_GRAVITY_STEP, 32'h8000_0000));
    queue_row(write_row(REG_FLOOR_LEVEL, 32'h8000_0000));
    queue_row(point_row(mk_point(-400, 300, -100, 900, 0, 0, 1'b0, 1'b0, 0, 0),
                        1'b0, '0));
    queue_row(write_row(REG_GRAVITY_STEP, 32'h7FFF_FFFF));
    queue_row(write_row(REG_FLOOR_LEVEL, 32'h7FFF_FFFF));
    queue_row(point_row(mk_point(400, -300, 100, -900, 0, 0, 1'b1, 1'b0, 0, 0),
                        1'b0, '0));
  endtask

  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly points near the origin with small velocities, so the floor and the
  // pull both matter; now and then full-range or corner values
  function automatic item_t gen_point();
    item_t pt;
    int    pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      pt.pos_x  = $urandom;
      pt.pos_y  = $urandom;
      pt.prev_x = $urandom;
      pt.prev_y = $urandom;
      pt.home_x = $urandom;
      pt.home_y = $urandom;
    end else if (pick == 1) begin
      pt.pos_x  = edge_word();
      pt.pos_y  = edge_word();
      pt.prev_x = edge_word();
      pt.prev_y = edge_word();
      pt.home_x = edge_word();
      pt.home_y = edge_word();
    end else begin
      pt.pos_x  = 32'(int'($urandom_range(0, 2097152)) - 1048576);
      pt.pos_y  = 32'(int'($urandom_range(0, 2097152)) - 1048576);
      pt.prev_x = pt.pos_x + 32'(int'($urandom_range(0, 8192)) - 4096);
      pt.prev_y = pt.pos_y + 32'(int'($urandom_range(0, 8192)) - 4096);
      pt.home_x = pt.pos_x + 32'(int'($urandom_range(0, 131072)) - 65536);
      pt.home_y = pt.pos_y + 32'(int'($urandom_range(0, 131072)) - 65536);
    end
    pt.is_muscle   = 1'($urandom_range(0, 1));
    pt.pinned      = ($urandom_range(0, 7) == 0);
    pt.load_in     = $urandom;
    pt.exposure_in = 16'($urandom);
    return pt;
  endfunction

  // Both extremes first, then one fully random setting, then plausible ones
  function automatic cfg_t make_cfg(int unsigned phase);
    cfg_t c;
    case (phase)
      0: begin
        c.damping = 16'h0000; c.gravity_step = 32'h8000_0000;
        c.skin_shape_gain = 16'h0000; c.muscle_shape_gain = 16'h0000;
        c.floor_friction = 16'h0000; c.floor_level = 32'h8000_0000;
      end
      1: begin
        c.damping = 16'hFFFF; c.gravity_step = 32'h7FFF_FFFF;
        c.skin_shape_gain = 16'hFFFF; c.muscle_shape_gain = 16'hFFFF;
        c.floor_friction = 16'hFFFF; c.floor_level = 32'h7FFF_FFFF;
      end
      2: begin
        c.damping = 16'($urandom); c.gravity_step = $urandom;
        c.skin_shape_gain = 16'($urandom); c.muscle_shape_gain = 16'($urandom);
        c.floor_friction = 16'($urandom); c.floor_level = $urandom;
      end
      default: begin
        c.damping = 16'($urandom_range(58000, 65535));
        c.gravity_step = 32'(int'($urandom_range(0, 8192)) - 4096);
        c.skin_shape_gain = 16'($urandom_range(0, 8000));
        c.muscle_shape_gain = 16'($urandom);
        c.floor_friction = 16'($urandom);
        c.floor_level = 32'(int'($urandom_range(0, 524288)) - 262144);
      end
    endcase
    return c;
  endfunction

  // Receiver: short stalls, long open runs, and twice a long hold-off that lets
  // the pipeline fill and push back on the sender
  initial begin : result_sink
    int unsigned run;
    int unsigned hold_idx;
    int unsigned hold_mark[2];
    hold_idx     = 0;
    hold_mark[0] = 300;
    hold_mark[1] = 750;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_idx < 2 && results_seen >= hold_mark[hold_idx]) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_idx++;
      end else if ($urandom_range(0, 5) == 0) begin
        run = $urandom_range(40, 120);
        repeat (run) @(negedge clk) out_if.ready <= 1'b1;
      end else begin
        run = $urandom_range(1, 8);
        repeat (run) @(negedge clk) out_if.ready <= 1'b1;
        run = $urandom_range(1, 4);
        repeat (run) @(negedge clk) out_if.ready <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("timeout: results still outstanding");
    $display("CHECKS FAILED");
    $finish;
  end

  // Main sequence: reset, directed table, random phases, drain, verdict
  initial begin : stimulus
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    rst_n        = 1'b0;
    burst_left   = 0;
    mismatches   = 0;
    results_seen = 0;

    // Register values after reset
    shadow_cfg.damping           = 16'hFFFF;
    shadow_cfg.gravity_step      = 32'h0000_0000;
    shadow_cfg.skin_shape_gain   = 16'h0000;
    shadow_cfg.muscle_shape_gain = 16'h0000;
    shadow_cfg.floor_friction    = 16'h0000;
    shadow_cfg.floor_level       = 32'h7FFF_FFFF;

    fill_directed();

    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the table; registers change only once the pipeline is empty
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WRITE) begin
        wait_settled();
        write_reg(directed[i].idx, directed[i].wdata);
      end else begin
        send_point(directed[i].pt, directed[i].typed, directed[i].want);
      end
    end

    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      wait_settled();
      apply_cfg(make_cfg(phase), (phase % 2) == 1);
      repeat (PointsPerPhase) send_point(gen_point(), 1'b0, '0);
    end

    // Drain, then keep clocking so anything spurious can still show up
    wait_settled();
    repeat (NumStages * 4) @(posedge clk);
    if (stepped_due.size() != 0) begin
      report_mismatch("results still due at end", 32'(stepped_due.size()), '0);
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* point_verlet_integrator_top.f */
src/vrl_pkg.sv
src/vrl_stream_if.sv
src/vrl_pipe.sv
src/vrl_motion.sv
src/vrl_settle.sv
src/point_verlet_integrator_top.sv
src/vrl_checker.sv
sim/point_verlet_integrator_top_tb.sv
